### rtl/signed_int_to_decimal_ascii_assert.svh
// assertion macros for the signed integer to decimal text converter
// expects clk and rst_n in the scope where a macro is used
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`ifndef ASSERT_OFF
`define SIDA_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SIDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SIDA_ASSERT_IMPLY(label, ante, cons, msg)
`define SIDA_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### rtl/sida_pkg.sv
// shared types and character constants for the decimal text converter
// no dependencies
package sida_pkg;

    localparam logic [6:0] CHAR_MINUS = 7'd45;
    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_NINE  = 7'd57;

    typedef logic [3:0] digit_t;

    // control broadcast from the sequencer to every digit cell
    typedef struct packed {
        logic clear;
        logic convert;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SKIP = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

endpackage

### rtl/sida_digit_cell.sv
// one decimal digit of the shift-and-add-3 chain
// depends on sida_pkg
module sida_digit_cell
(
    input  logic                 clk,
    input  sida_pkg::cell_ctrl_t ctrl,
    input  logic                 carry_in,
    input  sida_pkg::digit_t     digit_in,
    output logic                 carry_out,
    output sida_pkg::digit_t     digit
);

    sida_pkg::digit_t digit_reg;
    sida_pkg::digit_t digit_next;
    sida_pkg::digit_t adj;

    // add 3 before the doubling so the digit wraps at ten
    always_comb
    begin
        adj       = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
        carry_out = adj[3];
    end

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = 4'd0;
        end
        else if (ctrl.convert)
        begin
            digit_next = {adj[2:0], carry_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

    assign digit = digit_reg;

endmodule

### rtl/signed_int_to_decimal_ascii.sv
// Signed integer to decimal ASCII converter. Each accepted value is sent out as
// one character per output transaction: '-' for a negative value, then the
// digits most significant first with no leading zeros, the last one flagged by
// last_char. The magnitude is shifted one bit per cycle into a chain of BCD
// digit cells until all VALUE_BITS bits (32 by default) are in; leading
// zero digits are then dropped at one per cycle, and the characters follow at
// one per cycle while out_ready is high. A new value is taken once the last
// character has moved to the output register.
module signed_int_to_decimal_ascii
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [VALUE_BITS-1:0] value_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [6:0]                   char_code,
    output logic                         last_char
);

    localparam int NDIG  = (VALUE_BITS * 3 + 9) / 10;
    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam int REM_W = $clog2(NDIG + 1);

    sida_pkg::state_t state_reg, state_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic                  out_valid_reg, out_valid_next;
    logic [6:0]            char_reg, char_next;
    logic                  last_reg, last_next;

    logic [VALUE_BITS-1:0] raw;
    logic                  in_acc;
    logic                  out_free;
    sida_pkg::cell_ctrl_t  ctrl;
    sida_pkg::digit_t      digit_w [NDIG];
    logic                  carry_w [NDIG];
    sida_pkg::digit_t      top_digit;

    logic                  minus_out;
    logic                  char_ok;
    logic                  digit_phase;

    assign raw       = value_in;
    assign in_ready  = (state_reg == sida_pkg::S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign top_digit = digit_w[NDIG-1];

    genvar gi;
    generate
        for (gi = 0; gi < NDIG; gi++)
        begin : g_cell
            logic             cin;
            sida_pkg::digit_t din;
            if (gi == 0)
            begin : g_first
                assign cin = mag_reg[VALUE_BITS-1];
                assign din = 4'd0;
            end
            else
            begin : g_rest
                assign cin = carry_w[gi-1];
                assign din = digit_w[gi-1];
            end
            sida_digit_cell u_cell
            (
                .clk       (clk),
                .ctrl      (ctrl),
                .carry_in  (cin),
                .digit_in  (din),
                .carry_out (carry_w[gi]),
                .digit     (digit_w[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        ctrl           = '0;
        case (state_reg)
            sida_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    neg_next   = raw[VALUE_BITS-1];
                    mag_next   = raw[VALUE_BITS-1]
                               ? ((~raw) + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;
                    cnt_next   = '0;
                    ctrl.clear = 1'b1;
                    state_next = sida_pkg::S_CONV;
                end
            end
            sida_pkg::S_CONV:
            begin
                ctrl.convert = 1'b1;
                mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_BITS - 1))
                begin
                    rem_next   = REM_W'(NDIG);
                    state_next = sida_pkg::S_SKIP;
                end
            end
            sida_pkg::S_SKIP:
            begin
                // drop leading zeros, keeping at least one digit
                if (top_digit == 4'd0 && rem_reg != REM_W'(1))
                begin
                    ctrl.shift = 1'b1;
                    rem_next   = rem_reg - 1'b1;
                end
                else
                begin
                    state_next = sida_pkg::S_EMIT;
                end
            end
            sida_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (neg_reg)
                    begin
                        char_next = sida_pkg::CHAR_MINUS;
                        last_next = 1'b0;
                        neg_next  = 1'b0;
                    end
                    else
                    begin
                        char_next  = sida_pkg::CHAR_ZERO + {3'b000, top_digit};
                        last_next  = (rem_reg == REM_W'(1));
                        ctrl.shift = 1'b1;
                        rem_next   = rem_reg - 1'b1;
                        if (rem_reg == REM_W'(1))
                        begin
                            state_next = sida_pkg::S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = sida_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sida_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

    assign minus_out   = (char_code == sida_pkg::CHAR_MINUS);
    assign char_ok     = minus_out || ((char_code >= sida_pkg::CHAR_ZERO)
                                       && (char_code <= sida_pkg::CHAR_NINE));
    assign digit_phase = (state_reg == sida_pkg::S_EMIT) || (state_reg == sida_pkg::S_SKIP);

`include "signed_int_to_decimal_ascii_assert.svh"

    `SIDA_ASSERT_IMPLY(a_char_legal, out_valid, char_ok, "illegal character code")
    `SIDA_ASSERT_IMPLY(a_minus_not_last, out_valid && minus_out, !last_char, "minus flagged last")
    `SIDA_ASSERT_IMPLY(a_rem_nonzero, digit_phase, rem_reg != '0, "digit count ran out")
    `SIDA_ASSERT_NEXT(a_accept_conv, in_acc, state_reg == sida_pkg::S_CONV, "no conversion")

endmodule

### verif/tb_signed_int_to_decimal_ascii.sv
`timescale 1ns / 100ps
// testbench for signed_int_to_decimal_ascii: a directed table of values, then random values,
// with every output character compared against a predicted text queue
// depends on sida_pkg and the signed_int_to_decimal_ascii top level
module tb_signed_int_to_decimal_ascii;

    localparam int VALUE_BITS    = 32;
    localparam int DIRECTED_ROWS = 22;
    localparam int RANDOM_VALUES = 198;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_CYCLES  = 64;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } text_char_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic signed [VALUE_BITS-1:0] value_in;
    logic                         out_valid;
    logic                         out_ready;
    logic [6:0]                   char_code;
    logic                         last_char;

    text_char_t expected_text[$];
    int         error_count;
    int         cycle_count;

    // directed values; a text is typed in only where it is plain from the value
    int dir_values [DIRECTED_ROWS] = '{
        0, 1, -1, 2147483647, 32'h8000_0000, -2147483647,
        9, 10, -10, 99, 100, -101,
        999999999, 1000000000, -1000000000, 1234567890, -1234567890,
        32'h5555_5555, 32'hAAAA_AAAA, 7, -90000, 42
    };
    string dir_text [DIRECTED_ROWS] = '{
        "0", "1", "-1", "2147483647", "-2147483648", "-2147483647",
        "", "", "", "", "", "",
        "", "", "", "", "",
        "", "", "", "", ""
    };

    signed_int_to_decimal_ascii #(
        .VALUE_BITS (VALUE_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value_in  (value_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_code (char_code),
        .last_char (last_char)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d characters outstanding", $time,
                     expected_text.size());
            $display("tb_signed_int_to_decimal_ascii: errors");
            $finish;
        end
    end

    // sign, then decimal digits of the unsigned magnitude, most significant first
    function automatic void predict_text(input logic [VALUE_BITS-1:0] value);
        logic [VALUE_BITS-1:0] magnitude;
        logic [VALUE_BITS-1:0] remainder;
        logic [3:0]            digits[$];
        text_char_t            c;
        magnitude = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
        if (value[VALUE_BITS-1])
        begin
            c.code = sida_pkg::CHAR_MINUS;
            c.last = 1'b0;
            expected_text.push_back(c);
        end
        do
        begin
            remainder = magnitude % 10;
            digits.push_front(remainder[3:0]);
            magnitude = magnitude / 10;
        end
        while (magnitude != 0);
        for (int k = 0; k < digits.size(); k++)
        begin
            c.code = sida_pkg::CHAR_ZERO + digits[k];
            c.last = (k == digits.size() - 1);
            expected_text.push_back(c);
        end
    endfunction

    function automatic void expect_typed_text(input string text);
        byte        b;
        text_char_t c;
        for (int k = 0; k < text.len(); k++)
        begin
            b = text.getc(k);
            c.code = b[6:0];
            c.last = (k == text.len() - 1);
            expected_text.push_back(c);
        end
    endfunction

    // mix of values spread over digit counts, raw 32-bit patterns and powers of ten +/- 1
    function automatic logic [VALUE_BITS-1:0] random_value();
        int unsigned pick;
        int unsigned magnitude;
        int unsigned lo;
        int unsigned hi;
        int          num_digits;
        pick = $urandom_range(0, 9);
        if (pick >= 4 && pick < 8)
            return $urandom;
        if (pick < 4)
        begin
            num_digits = $urandom_range(1, 10);
            lo = 1;
            repeat (num_digits - 1) lo = lo * 10;
            hi = (num_digits == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
            if (num_digits == 1)
                lo = 0;
            magnitude = $urandom_range(hi, lo);
        end
        else
        begin
            magnitude = 1;
            repeat ($urandom_range(0, 9)) magnitude = magnitude * 10;
            magnitude = magnitude + $urandom_range(0, 2) - 1;
        end
        if ($urandom_range(0, 1) == 1)
            return ~magnitude + 1;
        return magnitude;
    endfunction

    // one input transaction; the expected text is queued at the accepting edge
    task automatic send_value(input logic [VALUE_BITS-1:0] value, input string typed,
                              input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        value_in <= value;
        do @(posedge clk); while (!in_ready);
        if (typed.len() != 0)
            expect_typed_text(typed);
        else
            predict_text(value);
    endtask

    // output side: random stalls, with stretches of none, and the character check
    initial
    begin
        int         stall;
        int         received;
        text_char_t want;
        out_ready = 1'b0;
        received  = 0;
        @(posedge rst_n);
        forever
        begin
            stall = ((received % 100) < 25) ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            received++;
            if (expected_text.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, actual code %0d last %0b",
                         $time, char_code, last_char);
                error_count++;
            end
            else
            begin
                want = expected_text.pop_front();
                if (char_code !== want.code)
                begin
                    $display("%0t: char_code mismatch: expected %0d, actual %0d",
                             $time, want.code, char_code);
                    error_count++;
                end
                if (last_char !== want.last)
                begin
                    $display("%0t: last_char mismatch: expected %0b, actual %0b",
                             $time, want.last, last_char);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        value_in    = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_value(dir_values[i], dir_text[i], (i % 50) < 10);
        for (int i = 0; i < RANDOM_VALUES; i++)
            send_value(random_value(), "", (i % 50) < 10);
        in_valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge clk);
        // let any stray character show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_signed_int_to_decimal_ascii: clean");
        else
            $display("tb_signed_int_to_decimal_ascii: errors");
        $finish;
    end

endmodule
